@@ hdl/tbr_pkg.sv @@
// Shared constants, types and codes for the timer bank.
package tbr_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int TIME_W      = 32;
  localparam int ENTRY_W     = 2 * TIME_W;
  localparam int MASK_W      = 16;
  localparam int EXT_W       = (TIMER_COUNT > MASK_W) ? TIMER_COUNT : MASK_W;
  localparam int REQ_IDX_W   = 4;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_STATUS = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_FILL,
    ST_TICK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;   // capture the request fields
    logic apply;  // carry out a start or stop
    logic fill;   // issue the read of the first entry
    logic step;   // check one entry and read the next
  } cmd_t;

  typedef struct packed {
    logic req_tick;  // request on the ports is a tick
    logic last;      // entry being checked is the final one
  } sts_t;

endpackage

@@ hdl/tbr_ram.sv @@
// Generic single-port-write, registered-read RAM.
module tbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tbr_ctrl.sv @@
// Controller state machine for the timer bank.
module tbr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tbr_pkg::sts_t sts,
  output tbr_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import tbr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = sts.req_tick ? ST_FILL : ST_OP;
        end
      end
      ST_OP:   state_next = ST_RESP;
      ST_FILL: state_next = ST_TICK;
      ST_TICK: begin
        if (sts.last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_OP:   cmd.apply = 1'b1;
      ST_FILL: cmd.fill  = 1'b1;
      ST_TICK: cmd.step  = 1'b1;
      ST_RESP: done      = 1'b1;
      default: busy      = 1'b1;
    endcase
  end

endmodule

@@ hdl/tbr_dp.sv @@
// Datapath: request registers, timer flags, entry RAM and the expiry check.
module tbr_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tbr_pkg::cmd_t                  cmd,
  output tbr_pkg::sts_t                  sts,
  input  logic [1:0]                     req_type,
  input  logic [tbr_pkg::REQ_IDX_W-1:0]  timer_index,
  input  logic [tbr_pkg::TIME_W-1:0]     now_ticks,
  input  logic [tbr_pkg::TIME_W-1:0]     period_ticks,
  input  logic                           repeat_mode,
  output logic                           is_running,
  output logic                           is_expired,
  output logic [tbr_pkg::MASK_W-1:0]     expired_mask
);
  import tbr_pkg::*;

  // Captured request.
  req_t                req_q;
  logic [REQ_IDX_W-1:0] idx_q;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   period_q;
  logic                rep_q;

  // Per-timer flags.
  logic [TIMER_COUNT-1:0] run_flags, run_flags_next;
  logic [TIMER_COUNT-1:0] rep_flags, rep_flags_next;
  logic [TIMER_COUNT-1:0] exp_flags, exp_flags_next;

  // Entry currently being checked during a tick sweep.
  logic [IDX_W-1:0] proc;

  logic [7:0]       idx_wide;
  logic [IDX_W-1:0] idx_addr;
  logic             idx_valid;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [TIME_W-1:0] elapsed;
  logic              hit;
  logic [EXT_W-1:0]  exp_ext;

  assign idx_wide  = {4'b0, idx_q};
  assign idx_addr  = idx_wide[IDX_W-1:0];
  assign idx_valid = (idx_wide < 8'(TIMER_COUNT));

  assign sts.req_tick = (req_t'(req_type) == REQ_TICK);
  assign sts.last     = (proc == IDX_W'(TIMER_COUNT - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= req_t'(req_type);
      idx_q    <= timer_index;
      now_q    <= now_ticks;
      period_q <= period_ticks;
      rep_q    <= repeat_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc <= '0;
    end else if (cmd.fill) begin
      proc <= '0;
    end else if (cmd.step) begin
      proc <= proc + IDX_W'(1);
    end
  end

  // The entry holds the period in the upper half and the base in the lower.
  assign elapsed = now_q - ram_rdata[TIME_W-1:0];
  assign hit     = (elapsed >= ram_rdata[ENTRY_W-1:TIME_W]);

  assign ram_raddr = cmd.fill ? '0 : (proc + IDX_W'(1));

  always_comb begin
    run_flags_next = run_flags;
    rep_flags_next = rep_flags;
    exp_flags_next = exp_flags;
    ram_we         = 1'b0;
    ram_waddr      = proc;
    ram_wdata      = {ram_rdata[ENTRY_W-1:TIME_W], now_q};
    if (cmd.apply && idx_valid) begin
      case (req_q)
        REQ_START: begin
          ram_we                   = 1'b1;
          ram_waddr                = idx_addr;
          ram_wdata                = {period_q, now_q};
          run_flags_next[idx_addr] = 1'b1;
          rep_flags_next[idx_addr] = rep_q;
          exp_flags_next[idx_addr] = (period_q == '0);
        end
        REQ_STOP: begin
          run_flags_next[idx_addr] = 1'b0;
          exp_flags_next[idx_addr] = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cmd.step) begin
      if (run_flags[proc] && hit) begin
        exp_flags_next[proc] = 1'b1;
        if (rep_flags[proc]) begin
          // A repeating timer rebases to the current time and keeps its period.
          ram_we = 1'b1;
        end else begin
          run_flags_next[proc] = 1'b0;
        end
      end else begin
        exp_flags_next[proc] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flags <= '0;
      rep_flags <= '0;
      exp_flags <= '0;
    end else begin
      run_flags <= run_flags_next;
      rep_flags <= rep_flags_next;
      exp_flags <= exp_flags_next;
    end
  end

  tbr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_COUNT)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign exp_ext      = EXT_W'(exp_flags);
  assign expired_mask = exp_ext[MASK_W-1:0];
  assign is_running   = idx_valid && run_flags[idx_addr];
  assign is_expired   = idx_valid && exp_flags[idx_addr];

endmodule

@@ hdl/timer_bank_oneshot_repeat.sv @@
// Start, stop and status transactions pass through the OP state and show their result in RESP.
// A tick transaction passes through FILL, then a sweep in TICK that checks one entry per cycle
// through the single read port of the entry RAM, and then shows its result in RESP.
// One transaction is in flight at a time, so a new one is taken only once the block is idle
// again after the result of the last one has been shown.
// The result stands for exactly one cycle under done and the receiver cannot stall it.
// Synchronous reset clears the running, repeat and expired flags but not the entry RAM.
module timer_bank_oneshot_repeat (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    req_type,
  input  logic [tbr_pkg::REQ_IDX_W-1:0] timer_index,
  input  logic [tbr_pkg::TIME_W-1:0]    now_ticks,
  input  logic [tbr_pkg::TIME_W-1:0]    period_ticks,
  input  logic                          repeat_mode,
  output logic                          busy,
  output logic                          done,
  output logic                          is_running,
  output logic                          is_expired,
  output logic [tbr_pkg::MASK_W-1:0]    expired_mask
);
  import tbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tbr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tbr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .timer_index  (timer_index),
    .now_ticks    (now_ticks),
    .period_ticks (period_ticks),
    .repeat_mode  (repeat_mode),
    .is_running   (is_running),
    .is_expired   (is_expired),
    .expired_mask (expired_mask)
  );

  // An accepted transaction keeps the block busy from the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  // The result strobe lasts a single cycle and only while busy.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (busy ##1 !done))
    else $error("done strobe malformed");

  // A start leaves its timer running when the result is shown.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_START && 32'(timer_index) < TIMER_COUNT)
      |-> ##2 (done && is_running))
    else $error("started timer not reported as running");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the timer bank: directed and random transactions.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  typedef struct packed {
    logic              running;
    logic              expired;
    logic [MASK_W-1:0] mask;
  } status_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic [1:0]           req_type;
  logic [REQ_IDX_W-1:0] timer_index;
  logic [TIME_W-1:0]    now_ticks;
  logic [TIME_W-1:0]    period_ticks;
  logic                 repeat_mode;
  logic                 busy;
  logic                 done;
  logic                 is_running;
  logic                 is_expired;
  logic [MASK_W-1:0]    expired_mask;

  // Mirror of the timer bank state.
  logic [TIME_W-1:0] bank_base   [TIMER_COUNT];
  logic [TIME_W-1:0] bank_period [TIMER_COUNT];
  logic [EXT_W-1:0]  bank_running;
  logic [EXT_W-1:0]  bank_repeat;
  logic [EXT_W-1:0]  bank_expired;

  status_t pending_status[$];
  int      error_count;

  timer_bank_oneshot_repeat u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .timer_index  (timer_index),
    .now_ticks    (now_ticks),
    .period_ticks (period_ticks),
    .repeat_mode  (repeat_mode),
    .busy         (busy),
    .done         (done),
    .is_running   (is_running),
    .is_expired   (is_expired),
    .expired_mask (expired_mask)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timer_bank_oneshot_repeat: mismatch");
    $finish;
  end

  // Update the mirrored bank for one accepted transaction and queue the status it returns.
  task automatic apply_to_bank(input req_t req, input logic [REQ_IDX_W-1:0] idx,
                               input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] period,
                               input logic rep);
    status_t    res;
    logic       valid;
    logic [TIME_W-1:0] elapsed;
    valid = (int'(idx) < TIMER_COUNT);
    case (req)
      REQ_TICK: begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
          if (!bank_running[t]) begin
            bank_expired[t] = 1'b0;
          end else begin
            elapsed = now - bank_base[t];
            if (elapsed >= bank_period[t]) begin
              bank_expired[t] = 1'b1;
              if (bank_repeat[t]) bank_base[t] = now;
              else bank_running[t] = 1'b0;
            end else begin
              bank_expired[t] = 1'b0;
            end
          end
        end
      end
      REQ_START: begin
        if (valid) begin
          bank_base[idx]    = now;
          bank_period[idx]  = period;
          bank_running[idx] = 1'b1;
          bank_expired[idx] = (period == '0);
          bank_repeat[idx]  = rep;
        end
      end
      REQ_STOP: begin
        if (valid) begin
          bank_running[idx] = 1'b0;
          bank_expired[idx] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.running = valid && bank_running[idx];
    res.expired = valid && bank_expired[idx];
    res.mask    = bank_expired[MASK_W-1:0];
    pending_status.push_back(res);
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic send_req(input req_t req, input logic [REQ_IDX_W-1:0] idx,
                          input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] period,
                          input logic rep);
    start        <= 1'b1;
    req_type     <= req;
    timer_index  <= idx;
    now_ticks    <= now;
    period_ticks <= period;
    repeat_mode  <= rep;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_bank(req, idx, now, period, rep);
  endtask

  // Mostly short gaps, now and then a long one.
  task automatic idle_gap(input bit allow);
    int n;
    n = 0;
    if (allow) begin
      if ($urandom_range(0, 15) == 0) n = $urandom_range(16, 60);
      else n = $urandom_range(0, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_gap(input req_t req, input logic [REQ_IDX_W-1:0] idx,
                          input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] period,
                          input logic rep);
    send_req(req, idx, now, period, rep);
    idle_gap(1'b1);
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with no transaction pending: running %0h expired %0h mask %0h",
                 $time, is_running, is_expired, expired_mask);
        error_count++;
      end else begin
        want = pending_status.pop_front();
        if (is_running !== want.running) begin
          $display("%0t: is_running expected %0h actual %0h", $time, want.running, is_running);
          error_count++;
        end
        if (is_expired !== want.expired) begin
          $display("%0t: is_expired expected %0h actual %0h", $time, want.expired, is_expired);
          error_count++;
        end
        if (expired_mask !== want.mask) begin
          $display("%0t: expired_mask expected %0h actual %0h", $time, want.mask,
                   expired_mask);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_status();
    send_gap(REQ_STATUS, 4'd0, 32'h0, 32'h0, 1'b0);
    send_gap(REQ_STATUS, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_gap(REQ_TICK, 4'd9, 32'h0, 32'h0, 1'b0);
  endtask

  task automatic test_zero_period();
    send_gap(REQ_START, 4'd3, 32'd5, 32'd0, 1'b0);
    send_gap(REQ_TICK, 4'd3, 32'd5, 32'd0, 1'b0);
    send_gap(REQ_TICK, 4'd3, 32'd6, 32'd0, 1'b0);
  endtask

  task automatic test_one_shot();
    send_gap(REQ_START, 4'd0, 32'd100, 32'd10, 1'b0);
    send_gap(REQ_TICK, 4'd0, 32'd105, 32'd0, 1'b0);
    send_gap(REQ_TICK, 4'd0, 32'd110, 32'd0, 1'b0);
    send_gap(REQ_STATUS, 4'd0, 32'd0, 32'd0, 1'b0);
    send_gap(REQ_TICK, 4'd0, 32'd200, 32'd0, 1'b0);
  endtask

  // The repeating timer is started just before the time wraps.
  task automatic test_repeat_wrap();
    send_gap(REQ_START, 4'd15, 32'hFFFF_FFF0, 32'h20, 1'b1);
    send_gap(REQ_TICK, 4'd15, 32'h8, 32'h0, 1'b0);
    send_gap(REQ_TICK, 4'd15, 32'h10, 32'h0, 1'b0);
    send_gap(REQ_TICK, 4'd15, 32'h11, 32'h0, 1'b0);
    send_gap(REQ_STATUS, 4'd15, 32'h0, 32'h0, 1'b0);
  endtask

  task automatic test_stop();
    send_gap(REQ_START, 4'd7, 32'd0, 32'd1, 1'b1);
    send_gap(REQ_TICK, 4'd7, 32'd1, 32'd0, 1'b0);
    send_gap(REQ_STOP, 4'd7, 32'd0, 32'd0, 1'b0);
    send_gap(REQ_STOP, 4'd2, 32'd0, 32'd0, 1'b0);
  endtask

  task automatic test_extremes();
    send_gap(REQ_START, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_gap(REQ_TICK, 4'd8, 32'hFFFF_FFFD, 32'h0, 1'b0);
    send_gap(REQ_TICK, 4'd8, 32'hFFFF_FFFE, 32'h0, 1'b0);
    send_gap(REQ_STATUS, 4'd8, 32'h0, 32'h0, 1'b0);
  endtask

  // A running clock advances in small steps so that timers expire often; now and then it jumps.
  task automatic test_random_traffic(input int count);
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] item_now;
    logic [TIME_W-1:0] period;
    req_t              req;
    int                pick;
    clock_now = $urandom;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) req = REQ_TICK;
      else if (pick < 72) req = REQ_START;
      else if (pick < 84) req = REQ_STOP;
      else req = REQ_STATUS;

      pick = $urandom_range(0, 99);
      if (pick < 88) clock_now = clock_now + $urandom_range(0, 24);
      else if (pick < 94) clock_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else clock_now = $urandom;
      item_now = (req == REQ_STATUS || req == REQ_STOP) ? $urandom : clock_now;

      pick = $urandom_range(0, 99);
      if (pick < 10) period = '0;
      else if (pick < 70) period = $urandom_range(1, 40);
      else if (pick < 80) period = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else period = $urandom;

      send_req(req, REQ_IDX_W'($urandom_range(0, 15)), item_now, period,
               1'($urandom_range(0, 1)));
      idle_gap((i / 200) % 3 != 1);
    end
  endtask

  initial begin
    int drain_cycles;
    bit drain_timeout;
    error_count  = 0;
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_TICK;
    timer_index  = '0;
    now_ticks    = '0;
    period_ticks = '0;
    repeat_mode  = 1'b0;
    bank_running = '0;
    bank_repeat  = '0;
    bank_expired = '0;
    for (int t = 0; t < TIMER_COUNT; t++) begin
      bank_base[t]   = '0;
      bank_period[t] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_status();
    test_zero_period();
    test_one_shot();
    test_repeat_wrap();
    test_stop();
    test_extremes();
    test_random_traffic(1630);
    start <= 1'b0;

    drain_cycles  = 0;
    drain_timeout = 1'b0;
    while (pending_status.size() != 0 && !drain_timeout) begin
      @(posedge clk);
      drain_cycles++;
      if (drain_cycles > 1000) drain_timeout = 1'b1;
    end
    repeat (TIMER_COUNT + 8) @(posedge clk);

    if (drain_timeout || pending_status.size() != 0) begin
      $display("timer_bank_oneshot_repeat: mismatch");
    end else if (error_count == 0) begin
      $display("timer_bank_oneshot_repeat: match");
    end else begin
      $display("timer_bank_oneshot_repeat: mismatch");
    end
    $finish;
  end

endmodule
